// File: rtl/vtm_pkg.sv
// shared types and codes for the virtual timer multiplexer
`timescale 1ns / 1ps

package vtm_pkg;

    // input operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam int DUR_W = 32;
    localparam int ID_W  = 4;

    typedef enum logic [1:0] {
        RES_STARTED   = 2'd0,
        RES_EXPIRED   = 2'd1,
        RES_CANCELLED = 2'd2,
        RES_REFUSED   = 2'd3
    } t_res_kind;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_CANCEL
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [DUR_W-1:0]   duration;
        logic               rep;
        logic [ID_W-1:0]    cid;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_FLUSH,
        S_START,
        S_CANCEL
    } t_state;

endpackage

// File: rtl/vtm_if.sv
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps

interface vtm_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] duration;
    logic        repeat_req;
    logic [3:0]  cancel_id;

    modport source (output valid, output op, output duration, output repeat_req,
                    output cancel_id, input ready);
    modport sink   (input valid, input op, input duration, input repeat_req,
                    input cancel_id, output ready);
endinterface

interface vtm_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [3:0]  slot_id;
    logic        last;

    modport source (output valid, output result_kind, output slot_id, output last,
                    input ready);
    modport sink   (input valid, input result_kind, input slot_id, input last,
                    output ready);
endinterface

// File: rtl/virtual_timer_multiplexer.sv
// top level of the virtual timer multiplexer
//
//  channel   dir  beat payload                                  handshake
//  i_cmd     in   op, duration, repeat_req, cancel_id           valid / ready
//  o_res     out  result_kind, slot_id, last                    valid / ready
//
// a tick is dispatched from idle, then the slot table in one ram read port is walked
// one slot a cycle, holding while a second expiry waits on a busy result register;
// a final beat with last set follows when any timer expires.
// a start walks to the first free slot and is refused when none is free.
// reset clears the counter and all slot active bits; no clearing pass.
// commands wait in a two-beat queue; a new result waits until the held beat is taken.
`timescale 1ns / 1ps

module virtual_timer_multiplexer #(
    parameter int NUM_TIMERS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vtm_cmd_if.sink   i_cmd,
    vtm_res_if.source o_res
);
    import vtm_pkg::*;

    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    vtm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    vtm_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

// File: rtl/vtm_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module vtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/vtm_front.sv
// command intake: decode, duration fix-up and a two-entry command queue
`timescale 1ns / 1ps

module vtm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vtm_cmd_if.sink       i_cmd,
    output logic          o_q_valid,
    output vtm_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);
    import vtm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr, n_rd_ptr;
    logic [1:0] n_count;

    logic w_accept, w_push, w_pop;
    t_cmd w_cmd;

    assign i_cmd.ready = (r_count != 2'd2);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    always_comb begin
        w_cmd.duration = (i_cmd.duration == '0) ? DUR_W'(1) : i_cmd.duration;
        w_cmd.rep      = i_cmd.repeat_req;
        w_cmd.cid      = i_cmd.cancel_id;
        w_cmd.kind     = CMD_TICK;
        w_push         = 1'b0;
        unique case (i_cmd.op)
            OP_TICK: begin
                w_cmd.kind = CMD_TICK;
                w_push     = w_accept;
            end
            OP_START: begin
                w_cmd.kind = CMD_START;
                w_push     = w_accept;
            end
            OP_CANCEL: begin
                w_cmd.kind = CMD_CANCEL;
                w_push     = w_accept;
            end
            // undefined op is taken and dropped
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_cmd   = r_mem[r_rd_ptr];
    assign w_pop     = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// File: rtl/vtm_back.sv
// timer engine: slot table scan, start, cancel and result register
`timescale 1ns / 1ps

module vtm_back #(
    parameter int NUM_TIMERS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  vtm_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    vtm_res_if.source     o_res
);
    import vtm_pkg::*;

    localparam int IW    = $clog2(NUM_TIMERS);
    localparam int RAM_W = 1 + 2 * DUR_W;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_idx, n_idx;
    logic [DUR_W-1:0]      r_now, n_now;
    logic [NUM_TIMERS-1:0] r_active, n_active;
    logic                  r_pend_v, n_pend_v;
    logic [IW-1:0]         r_pend_id, n_pend_id;
    logic                  r_out_valid, n_out_valid;

    // latched command and result payload
    logic [DUR_W-1:0] r_dur;
    logic             r_rep;
    logic [ID_W-1:0]  r_cid;
    t_res_kind        r_out_kind;
    logic [ID_W-1:0]  r_out_id;
    logic             r_out_last;

    logic             w_emit;
    t_res_kind        w_emit_kind;
    logic [ID_W-1:0]  w_emit_id;
    logic             w_emit_last;

    logic             w_we;
    logic [IW-1:0]    w_waddr, w_raddr;
    logic [RAM_W-1:0] w_wdata, w_rdata;

    logic             w_rd_rep;
    logic [DUR_W-1:0] w_rd_period, w_rd_deadline;

    logic          w_out_free, w_match, w_idx_last, w_slot_free, w_cid_ok, w_tick_stall;
    logic [IW-1:0] w_cid_idx;

    vtm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (w_waddr),
        .i_wr_data (w_wdata),
        .i_rd_addr (w_raddr),
        .o_rd_data (w_rdata)
    );

    assign {w_rd_rep, w_rd_period, w_rd_deadline} = w_rdata;

    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_match      = r_active[r_idx] && (w_rd_deadline == r_now);
    assign w_idx_last   = (r_idx == IW'(NUM_TIMERS - 1));
    assign w_slot_free  = !r_active[r_idx];
    assign w_cid_idx    = IW'(r_cid);
    assign w_cid_ok     = (32'(r_cid) < NUM_TIMERS) && r_active[w_cid_idx];
    // a second hit cannot be taken until the held one has gone out
    assign w_tick_stall = w_match && r_pend_v && !w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.kind)
                        CMD_TICK:   n_state = S_TICK;
                        CMD_START:  n_state = S_START;
                        CMD_CANCEL: n_state = S_CANCEL;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK: begin
                if (!w_tick_stall && w_idx_last) begin
                    n_state = (w_match || r_pend_v) ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            S_START: begin
                if ((w_slot_free || w_idx_last) && w_out_free) n_state = S_IDLE;
            end
            S_CANCEL: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_q_pop     = 1'b0;
        n_idx       = r_idx;
        n_now       = r_now;
        n_active    = r_active;
        n_pend_v    = r_pend_v;
        n_pend_id   = r_pend_id;
        w_emit      = 1'b0;
        w_emit_kind = RES_EXPIRED;
        w_emit_id   = ID_W'(r_pend_id);
        w_emit_last = 1'b1;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = {w_rd_rep, w_rd_period, w_rd_deadline + w_rd_period};
        w_raddr     = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                n_idx   = '0;
                w_raddr = '0;
                if (i_q_valid && i_q_cmd.kind == CMD_TICK) begin
                    n_now = r_now + DUR_W'(1);
                end
            end
            S_TICK: begin
                if (!w_tick_stall) begin
                    w_raddr = r_idx + IW'(1);
                    n_idx   = r_idx + IW'(1);
                    if (w_match) begin
                        if (w_rd_rep) begin
                            w_we = 1'b1;
                        end else begin
                            n_active[r_idx] = 1'b0;
                        end
                        // emit the held hit, keep this one back for the last flag
                        if (r_pend_v) begin
                            w_emit      = 1'b1;
                            w_emit_last = 1'b0;
                        end
                        n_pend_v  = 1'b1;
                        n_pend_id = r_idx;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_emit   = 1'b1;
                    n_pend_v = 1'b0;
                end
            end
            S_START: begin
                w_wdata = {r_rep, r_dur, r_now + r_dur};
                if (w_slot_free) begin
                    if (w_out_free) begin
                        w_we            = 1'b1;
                        n_active[r_idx] = 1'b1;
                        w_emit          = 1'b1;
                        w_emit_kind     = RES_STARTED;
                        w_emit_id       = ID_W'(r_idx);
                    end
                end else if (w_idx_last) begin
                    if (w_out_free) begin
                        w_emit      = 1'b1;
                        w_emit_kind = RES_REFUSED;
                        w_emit_id   = '0;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_CANCEL: begin
                w_emit_id = r_cid;
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (w_cid_ok) begin
                        n_active[w_cid_idx] = 1'b0;
                        w_emit_kind         = RES_CANCELLED;
                    end else begin
                        w_emit_kind = RES_REFUSED;
                    end
                end
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_now       <= '0;
            r_active    <= '0;
            r_pend_v    <= 1'b0;
            r_pend_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_now       <= n_now;
            r_active    <= n_active;
            r_pend_v    <= n_pend_v;
            r_pend_id   <= n_pend_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_dur <= i_q_cmd.duration;
            r_rep <= i_q_cmd.rep;
            r_cid <= i_q_cmd.cid;
        end
        if (w_emit) begin
            r_out_kind <= w_emit_kind;
            r_out_id   <= w_emit_id;
            r_out_last <= w_emit_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out_kind;
    assign o_res.slot_id     = r_out_id;
    assign o_res.last        = r_out_last;

endmodule

// File: test/tb_virtual_timer_multiplexer.sv
// testbench for the virtual timer multiplexer: directed table, then random commands
`timescale 1ns / 1ps

module tb_virtual_timer_multiplexer;
    import vtm_pkg::*;

    localparam int          NUM_SLOTS   = 16;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          N_RANDOM    = 500;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN       = 80;
    localparam logic [31:0] DUR_MAX     = 32'hFFFF_FFFF;

    typedef struct {
        t_res_kind   kind;
        logic [3:0]  id;
        logic        last;
    } t_timer_res;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] dur;
        logic        rep;
        logic [3:0]  cid;
        int          reps;
        bit          typed;
        t_res_kind   kind;
        logic [3:0]  id;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    vtm_cmd_if cmd_bus ();
    vtm_res_if res_bus ();

    virtual_timer_multiplexer #(.NUM_TIMERS(NUM_SLOTS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    // timer table as the block should hold it
    logic [31:0] tb_now;
    logic        tb_active   [NUM_SLOTS];
    logic [31:0] tb_deadline [NUM_SLOTS];
    logic [31:0] tb_period   [NUM_SLOTS];
    logic        tb_periodic [NUM_SLOTS];

    t_timer_res  pending_reports[$];
    int          err_count = 0;
    bit          calm      = 1'b0;
    bit          hold_req  = 1'b0;

    // typed-in expectation that travels with the current command beat
    bit          row_typed;
    t_res_kind   row_kind;
    logic [3:0]  row_id;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic predict_timer_op(input logic [1:0] op, input logic [31:0] dur,
                                    input logic rep, input logic [3:0] cid);
        t_timer_res  r;
        int          hits;
        int          seen;
        logic [31:0] d;
        bit          placed;
        hits   = 0;
        seen   = 0;
        placed = 1'b0;
        case (op)
            OP_TICK: begin
                tb_now = tb_now + 32'd1;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tb_active[i] && tb_deadline[i] == tb_now) hits++;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tb_active[i] && tb_deadline[i] == tb_now) begin
                        seen++;
                        r.kind = RES_EXPIRED;
                        r.id   = i[3:0];
                        r.last = (seen == hits);
                        pending_reports.push_back(r);
                        if (tb_periodic[i]) tb_deadline[i] = tb_deadline[i] + tb_period[i];
                        else tb_active[i] = 1'b0;
                    end
                end
            end
            OP_START: begin
                d = (dur == 32'd0) ? 32'd1 : dur;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!placed && !tb_active[i]) begin
                        placed         = 1'b1;
                        tb_active[i]   = 1'b1;
                        tb_deadline[i] = tb_now + d;
                        tb_period[i]   = d;
                        tb_periodic[i] = rep;
                        r.kind = RES_STARTED;
                        r.id   = i[3:0];
                    end
                end
                if (!placed) begin
                    r.kind = RES_REFUSED;
                    r.id   = 4'd0;
                end
                r.last = 1'b1;
                pending_reports.push_back(r);
            end
            OP_CANCEL: begin
                if (tb_active[cid]) begin
                    tb_active[cid] = 1'b0;
                    r.kind = RES_CANCELLED;
                end else begin
                    r.kind = RES_REFUSED;
                end
                r.id   = cid;
                r.last = 1'b1;
                pending_reports.push_back(r);
            end
            default: ;
        endcase
    endtask

    // accepted command beats feed the model
    always @(posedge i_clk) begin
        t_timer_res r;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            predict_timer_op(cmd_bus.op, cmd_bus.duration, cmd_bus.repeat_req,
                             cmd_bus.cancel_id);
            if (row_typed) begin
                void'(pending_reports.pop_back());
                r.kind = row_kind;
                r.id   = row_id;
                r.last = 1'b1;
                pending_reports.push_back(r);
            end
        end
    end

    // accepted result beats are checked against the oldest expectation
    always @(posedge i_clk) begin
        t_timer_res r;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d id %0d last %0d",
                                          res_bus.result_kind, res_bus.slot_id,
                                          res_bus.last));
            end else begin
                r = pending_reports.pop_front();
                if (res_bus.result_kind !== r.kind)
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              res_bus.result_kind, r.kind));
                if (res_bus.slot_id !== r.id)
                    report_mismatch($sformatf("slot_id %0d, expected %0d",
                                              res_bus.slot_id, r.id));
                if (res_bus.last !== r.last)
                    report_mismatch($sformatf("last %0d, expected %0d",
                                              res_bus.last, r.last));
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        res_bus.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // valid stays high across back-to-back beats; only a gap lowers it
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] dur, input logic rep,
                            input logic [3:0] cid, input bit typed, input t_res_kind kind,
                            input logic [3:0] id);
        if (!calm && $urandom_range(0, 3) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.op         <= op;
        cmd_bus.duration   <= dur;
        cmd_bus.repeat_req <= rep;
        cmd_bus.cancel_id  <= cid;
        row_typed          <= typed;
        row_kind           <= kind;
        row_id             <= id;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
    endtask

    function automatic t_stim_row mk_row(input logic [1:0] op, input logic [31:0] dur,
                                         input logic rep, input logic [3:0] cid,
                                         input int reps, input bit typed,
                                         input t_res_kind kind, input logic [3:0] id);
        t_stim_row s;
        s.op = op; s.dur = dur; s.rep = rep; s.cid = cid;
        s.reps = reps; s.typed = typed; s.kind = kind; s.id = id;
        return s;
    endfunction

    initial begin
        t_stim_row   dir_rows[$];
        t_stim_row   row;
        int          iter;
        int          rand_sent;
        int          sel;
        logic [1:0]  op;
        logic [31:0] dur;
        logic        rep;
        logic [3:0]  cid;

        tb_now = 32'd0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tb_active[i]   = 1'b0;
            tb_deadline[i] = 32'd0;
            tb_period[i]   = 32'd0;
            tb_periodic[i] = 1'b0;
        end

        i_rst_n            <= 1'b0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.op         <= OP_TICK;
        cmd_bus.duration   <= 32'd0;
        cmd_bus.repeat_req <= 1'b0;
        cmd_bus.cancel_id  <= 4'd0;
        row_typed          <= 1'b0;
        row_kind           <= RES_STARTED;
        row_id             <= 4'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // op, duration, repeat, cancel id, times, typed, kind, id
        dir_rows.push_back(mk_row(OP_START,  32'd3,   1'b0, 4'd0,  1, 1, RES_STARTED,   4'd0));
        // zero duration acts as one tick, also as period
        dir_rows.push_back(mk_row(OP_START,  32'd0,   1'b1, 4'd0,  1, 1, RES_STARTED,   4'd1));
        dir_rows.push_back(mk_row(OP_TICK,   32'd0,   1'b0, 4'd0,  3, 0, RES_STARTED,   4'd0));
        dir_rows.push_back(mk_row(OP_CANCEL, 32'd0,   1'b0, 4'd1,  1, 1, RES_CANCELLED, 4'd1));
        dir_rows.push_back(mk_row(OP_CANCEL, 32'd0,   1'b0, 4'd1,  1, 1, RES_REFUSED,   4'd1));
        dir_rows.push_back(mk_row(OP_CANCEL, 32'd0,   1'b0, 4'd15, 1, 1, RES_REFUSED,   4'd15));
        // undefined op is dropped without a result
        dir_rows.push_back(mk_row(OP_UNUSED, DUR_MAX, 1'b1, 4'd15, 1, 0, RES_STARTED,   4'd0));
        // deadline wraps past the top of the counter
        dir_rows.push_back(mk_row(OP_START,  DUR_MAX, 1'b1, 4'd0,  1, 1, RES_STARTED,   4'd0));
        dir_rows.push_back(mk_row(OP_CANCEL, 32'd0,   1'b0, 4'd0,  1, 1, RES_CANCELLED, 4'd0));
        // fill the table with periodic timers sharing one deadline
        dir_rows.push_back(mk_row(OP_START,  32'd4,   1'b1, 4'd0, 16, 0, RES_STARTED,   4'd0));
        dir_rows.push_back(mk_row(OP_START,  32'd9,   1'b0, 4'd0,  1, 1, RES_REFUSED,   4'd0));
        // last of these ticks expires all sixteen slots at once
        dir_rows.push_back(mk_row(OP_TICK,   32'd0,   1'b0, 4'd0,  4, 0, RES_STARTED,   4'd0));
        dir_rows.push_back(mk_row(OP_CANCEL, 32'd0,   1'b0, 4'd7,  1, 1, RES_CANCELLED, 4'd7));
        dir_rows.push_back(mk_row(OP_START,  32'd1,   1'b0, 4'd0,  1, 0, RES_STARTED,   4'd0));
        dir_rows.push_back(mk_row(OP_TICK,   32'd0,   1'b0, 4'd0,  4, 0, RES_STARTED,   4'd0));
        dir_rows.push_back(mk_row(OP_CANCEL, 32'd0,   1'b0, 4'd0,  1, 1, RES_CANCELLED, 4'd0));

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            repeat (row.reps)
                send_cmd(row.op, row.dur, row.rep, row.cid, row.typed, row.kind, row.id);
        end

        iter      = 0;
        rand_sent = 0;
        while (rand_sent < N_RANDOM) begin
            calm = (rand_sent >= N_RANDOM - 80);
            if (iter == 150) hold_req = 1'b1;
            if (iter == 300) begin
                // let everything in flight come out before going on
                cmd_bus.valid <= 1'b0;
                @(posedge i_clk);
                while (pending_reports.size() != 0) @(posedge i_clk);
            end
            iter++;
            dur = $urandom;
            rep = 1'($urandom_range(0, 1));
            cid = 4'($urandom_range(0, 15));
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                op = OP_TICK;
            end else if (sel < 75) begin
                op  = OP_START;
                sel = $urandom_range(0, 9);
                if (sel == 1) dur = 32'd0;
                else if (sel > 1) dur = $urandom_range(1, 24);
            end else if (sel < 95) begin
                op = OP_CANCEL;
                // mostly aim at a live slot
                if ($urandom_range(0, 9) < 7)
                    repeat (15) if (!tb_active[cid]) cid = cid + 4'd1;
            end else begin
                op = OP_UNUSED;
            end
            send_cmd(op, dur, rep, cid, 1'b0, RES_STARTED, 4'd0);
            if (op != OP_UNUSED) rand_sent++;
        end

        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
